FILE: design/ufbd_pkg.sv
// Package: payload types and constants of the fractional baud divider calculator.
`timescale 1ns / 1ps
package ufbd_pkg;

    localparam logic [31:0] INC_LIMIT = 32'd65535;
    localparam logic [31:0] NUM_LIMIT = 32'd458745;
    localparam logic [31:0] PCT_DIV   = 32'd100;
    localparam logic [31:0] PCT_MUL   = 32'd3;
    localparam int          DIV_W     = 64;

    typedef struct packed {
        logic [27:0] baud_rate;
        logic [31:0] source_clock_hz;
    } t_in;

    typedef struct packed {
        logic [2:0]  rfdiv_code;
        logic [15:0] increment_value;
        logic [15:0] modulator_value;
        logic [31:0] baud_error;
        logic        accepted;
    } t_out;

    function automatic logic [2:0] rfdiv_of(input logic [2:0] d);
        logic [2:0] c;
        unique case (d)
            3'd1:    c = 3'd5;
            3'd2:    c = 3'd4;
            3'd3:    c = 3'd3;
            3'd4:    c = 3'd2;
            3'd5:    c = 3'd1;
            3'd6:    c = 3'd0;
            3'd7:    c = 3'd6;
            default: c = 3'd5;
        endcase
        return c;
    endfunction

endpackage

FILE: design/ufbd_divider.sv
// Shared restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module ufbd_divider #(
    parameter int W = ufbd_pkg::DIV_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q, n_q;
    logic [W-1:0]  r_r, n_r;
    logic [W-1:0]  r_d;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W:0]    w_sh;

    always_comb begin
        n_q = r_q;
        n_r = r_r;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh = {r_r, r_q[W-1]};
        if (r_busy) begin
            n_q = {r_q[W-2:0], 1'b0};
            if (w_sh >= {1'b0, r_d}) begin
                n_r = W'(w_sh - {1'b0, r_d});
                n_q[0] = 1'b1;
            end else begin
                n_r = w_sh[W-1:0];
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_q = i_num;
            n_r = '0;
            n_cnt = CW'(W);
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (!r_busy && i_start) r_d <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

FILE: design/uart_fractional_baud_divider_unit.sv
// Top level: fractional UART baud divider calculator around one serial divider.
//
// Usage: drive i_in with the wanted baud rate and the reference clock and
// hold start high; the transfer is taken at the first edge with busy low,
// and busy rises. The sequencer runs two Euclid GCD loops and a string of
// divisions on one shared 64-bit restoring divider. Each division is an
// issue state, 64 quotient steps and a done strobe. An item needs D
// divisions: both Euclid iteration counts plus 8, and 4 more when the
// fraction must be scaled down to fit. o_valid is raised by the S_OUT state,
// which follows the last division; zero inputs skip all divisions and go
// from idle straight to S_OUT, which raises o_valid and returns to idle.
// The result is shown on o_out for exactly one cycle with o_valid high;
// busy falls in that same cycle and the next item may be started at once.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Reset returns the sequencer to idle and drops busy and o_valid; no item
// in progress survives it. A zero baud rate or zero clock gives all zeros.
`timescale 1ns / 1ps
module uart_fractional_baud_divider_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ufbd_pkg::t_in  i_in,
    output logic           busy,
    output logic           o_valid,
    output ufbd_pkg::t_out o_out
);
    import ufbd_pkg::*;

    localparam int DW = DIV_W;

    localparam logic [4:0] S_IDLE = 5'd0,  S_G1 = 5'd1,  S_G1W = 5'd2,
                           S_NUM = 5'd3,   S_NUMW = 5'd4, S_DEN = 5'd5,
                           S_DENW = 5'd6,  S_M = 5'd7,   S_MW = 5'd8,
                           S_N = 5'd9,     S_NW = 5'd10, S_SN = 5'd11,
                           S_SNW = 5'd12,  S_SD = 5'd13, S_SDW = 5'd14,
                           S_DV = 5'd15,   S_DVW = 5'd16, S_G2 = 5'd17,
                           S_G2W = 5'd18,  S_TN = 5'd19, S_TNW = 5'd20,
                           S_TD = 5'd21,   S_TDW = 5'd22, S_AC = 5'd23,
                           S_ACW = 5'd24,  S_MOD = 5'd25, S_MODW = 5'd26,
                           S_TH = 5'd27,   S_THW = 5'd28, S_OUT = 5'd29;

    logic [4:0]  r_st, n_st;
    logic [31:0] r_baud, r_clk, r_ga, r_gb, r_num, r_den, r_mx;
    logic [31:0] r_tn, r_td, r_mod;
    logic [2:0]  r_dvd;
    logic [63:0] r_ach;
    logic        r_valid;
    t_out        r_out;

    logic          d_start;
    logic [DW-1:0] d_num, d_den, d_q, d_r;
    logic          d_done;

    ufbd_divider #(.W(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_num(d_num), .i_den(d_den), .o_done(d_done),
        .o_quot(d_q), .o_rem(d_r)
    );

    logic [31:0] w_q32, w_r32;
    assign w_q32 = d_q[31:0];
    assign w_r32 = d_r[31:0];

    logic [63:0] w_diff;
    assign w_diff = (r_ach >= {32'd0, r_baud}) ? r_ach - {32'd0, r_baud}
                                               : {32'd0, r_baud} - r_ach;

    // reduced denominator fits 16 bits once the fraction is scaled
    logic [47:0] w_prod;
    assign w_prod = 48'(r_tn) * 48'(r_den[15:0]);

    always_comb begin
        n_st = r_st;
        d_start = 1'b0;
        d_num = '0;
        d_den = '0;
        unique case (r_st)
            S_G1, S_G2: begin
                d_start = 1'b1;
                d_num = DW'(r_ga);
                d_den = DW'(r_gb);
            end
            S_NUM: begin d_start = 1'b1; d_num = DW'(r_clk); d_den = DW'(r_ga); end
            S_DEN: begin d_start = 1'b1; d_num = DW'(r_den); d_den = DW'(r_ga); end
            S_M:   begin
                d_start = 1'b1; d_num = DW'(r_num - 32'd1); d_den = DW'(NUM_LIMIT);
            end
            S_N:   begin
                d_start = 1'b1; d_num = DW'(r_den - 32'd1); d_den = DW'(INC_LIMIT);
            end
            S_SN:  begin d_start = 1'b1; d_num = DW'(r_num); d_den = DW'(r_mx); end
            S_SD:  begin d_start = 1'b1; d_num = DW'(r_den); d_den = DW'(r_mx); end
            S_DV:  begin
                d_start = 1'b1; d_num = DW'(r_num - 32'd1); d_den = DW'(INC_LIMIT);
            end
            S_TN:  begin d_start = 1'b1; d_num = DW'(r_clk); d_den = DW'(r_ga); end
            S_TD:  begin
                d_start = 1'b1; d_num = DW'({r_num[27:0], 4'd0}); d_den = DW'(r_ga);
            end
            S_AC:  begin
                d_start = 1'b1; d_num = DW'(w_prod); d_den = DW'(r_td);
            end
            S_MOD: begin d_start = 1'b1; d_num = DW'(r_num); d_den = DW'({29'd0, r_dvd}); end
            S_TH:  begin d_start = 1'b1; d_num = DW'(r_baud); d_den = DW'(PCT_DIV); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (start) begin
                    r_baud <= {4'd0, i_in.baud_rate};
                    r_clk <= i_in.source_clock_hz;
                    r_ga <= i_in.source_clock_hz;
                    r_gb <= {i_in.baud_rate, 4'd0};
                    r_den <= {i_in.baud_rate, 4'd0};
                    if (i_in.baud_rate == '0 || i_in.source_clock_hz == '0) begin
                        r_out <= '0;
                        r_st <= S_OUT;
                    end else r_st <= S_G1;
                end
                S_G1, S_G2, S_NUM, S_DEN, S_M, S_N, S_SN, S_SD, S_DV,
                S_TN, S_TD, S_AC, S_MOD, S_TH: r_st <= r_st + 5'd1;
                S_G1W, S_G2W: if (d_done) begin
                    // advance Euclid: a <- b, b <- a mod b
                    r_ga <= r_gb;
                    r_gb <= w_r32;
                    if (w_r32 == '0) r_st <= r_st + 5'd1;
                    else r_st <= r_st - 5'd1;
                end
                S_NUMW: if (d_done) begin r_num <= w_q32; r_st <= S_DEN; end
                S_DENW: if (d_done) begin
                    r_den <= w_q32;
                    if (r_num > NUM_LIMIT || w_q32 > INC_LIMIT) r_st <= S_M;
                    else r_st <= S_DV;
                end
                S_MW: if (d_done) begin r_mx <= w_q32 + 32'd1; r_st <= S_N; end
                S_NW: if (d_done) begin
                    if (w_q32 + 32'd1 > r_mx) r_mx <= w_q32 + 32'd1;
                    r_st <= S_SN;
                end
                S_SNW: if (d_done) begin
                    r_num <= (w_q32 == '0) ? 32'd1 : w_q32;
                    r_st <= S_SD;
                end
                S_SDW: if (d_done) begin
                    r_den <= (w_q32 == '0) ? 32'd1 : w_q32;
                    r_st <= S_DV;
                end
                S_DVW: if (d_done) begin
                    r_dvd <= 3'(w_q32 + 32'd1);
                    r_ga <= r_clk;
                    r_gb <= {r_num[27:0], 4'd0};
                    r_st <= S_G2;
                end
                S_TNW: if (d_done) begin r_tn <= w_q32; r_st <= S_TD; end
                S_TDW: if (d_done) begin r_td <= w_q32; r_st <= S_AC; end
                S_ACW: if (d_done) begin r_ach <= d_q; r_st <= S_MOD; end
                S_MODW: if (d_done) begin r_mod <= w_q32; r_st <= S_TH; end
                S_THW: if (d_done) begin
                    r_out.rfdiv_code <= rfdiv_of(r_dvd);
                    r_out.increment_value <= 16'(r_den - 32'd1);
                    r_out.modulator_value <= 16'(r_mod - 32'd1);
                    r_out.baud_error <= (w_diff[63:32] != '0) ? 32'hFFFF_FFFF
                                                              : w_diff[31:0];
                    r_out.accepted <= (w_diff < {32'd0, w_q32} * {32'd0, PCT_MUL});
                    r_st <= S_OUT;
                end
                S_OUT: begin r_valid <= 1'b1; r_st <= S_IDLE; end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_st != S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;
endmodule
